/* rtl/tcisd_pkg.sv */
// Shared types and constants of the twin circle island signed distance block.
// No dependencies; every other file imports this package.
package tcisd_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int RADIUS_W        = 31;
    localparam int DIST_W          = 35;
    localparam int NUM_LANES       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_A = 3'd0,
        REG_RADIUS_A = 3'd1,
        REG_CENTER_B = 3'd2,
        REG_RADIUS_B = 3'd3,
        REG_CENTER_C = 3'd4,
        REG_RADIUS_C = 3'd5,
        REG_INVERT   = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [NUM_LANES-1:0][CFG_DATA_W-1:0] center;
        logic [NUM_LANES-1:0][RADIUS_W-1:0]   radius;
        logic                                 invert;
    } t_cfg;

endpackage

/* rtl/tcisd_if.sv */
// Channel interfaces of the signed distance block: points, results, configuration.
// Depends on tcisd_pkg.
interface tcisd_point_if import tcisd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  point_x;
    logic signed [FIELD_W-1:0]  point_y;
    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface tcisd_dist_if import tcisd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  signed_distance;
    modport source (output valid, output signed_distance, input ready);
    modport sink   (input valid, input signed_distance, output ready);
endinterface

interface tcisd_cfg_if import tcisd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/tcisd_front.sv */
// Front stages: coordinate differences, absolute values, squares and squared sums.
// Depends on tcisd_pkg.
module tcisd_front import tcisd_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [FIELD_W-1:0]       i_px,
    input  logic [FIELD_W-1:0]       i_py,
    input  t_cfg                     i_cfg,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [2*COORD_WIDTH+1:0] o_sum [NUM_LANES]
);
    localparam int W  = COORD_WIDTH;
    localparam int AW = W + 1;
    localparam int NW = 2 * W + 2;

    logic [2:0]    r_v;
    logic [2:0]    w_rdy;
    logic [W-1:0]  w_px;
    logic [W-1:0]  w_py;
    logic [W:0]    w_dx [NUM_LANES];
    logic [W:0]    w_dy [NUM_LANES];
    logic [AW-1:0] n_ax [NUM_LANES];
    logic [AW-1:0] n_ay [NUM_LANES];
    logic [AW-1:0] r_ax [NUM_LANES];
    logic [AW-1:0] r_ay [NUM_LANES];
    logic [NW-1:0] r_sx [NUM_LANES];
    logic [NW-1:0] r_sy [NUM_LANES];
    logic [NW-1:0] r_sum [NUM_LANES];

    assign w_rdy[2] = !r_v[2] || i_ready;
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_v[2];
    assign w_px     = i_px[W-1:0];
    assign w_py     = i_py[W-1:0];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_dx[l] = {i_cfg.center[l][32+W-1], i_cfg.center[l][32+W-1:32]}
                      - {w_px[W-1], w_px};
            w_dy[l] = {i_cfg.center[l][W-1], i_cfg.center[l][W-1:0]}
                      - {w_py[W-1], w_py};
            n_ax[l] = w_dx[l][W] ? (~w_dx[l] + 1'b1) : w_dx[l];
            n_ay[l] = w_dy[l][W] ? (~w_dy[l] + 1'b1) : w_dy[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (w_rdy[0]) begin
                r_ax[l] <= n_ax[l];
                r_ay[l] <= n_ay[l];
            end
            if (w_rdy[1]) begin
                r_sx[l] <= NW'(r_ax[l]) * NW'(r_ax[l]);
                r_sy[l] <= NW'(r_ay[l]) * NW'(r_ay[l]);
            end
            if (w_rdy[2]) begin
                r_sum[l] <= r_sx[l] + r_sy[l];
            end
        end
    end

    assign o_sum = r_sum;
endmodule

/* rtl/tcisd_sqrt.sv */
// Pipelined integer square root, one root bit per stage, three lanes in step.
// Depends on tcisd_pkg.
module tcisd_sqrt import tcisd_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2*COORD_WIDTH+1:0] i_sum [NUM_LANES],
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [COORD_WIDTH:0]     o_root [NUM_LANES]
);
    localparam int W   = COORD_WIDTH;
    localparam int R   = W + 1;
    localparam int NW  = 2 * W + 2;
    localparam int RMW = R + 3;

    logic [R-1:0]   r_v;
    logic [R-1:0]   w_rdy;
    logic [RMW-1:0] r_rem  [R][NUM_LANES];
    logic [R-1:0]   r_root [R][NUM_LANES];
    logic [NW-1:0]  r_rest [R][NUM_LANES];

    genvar s;
    generate
        for (s = 0; s < R; s++) begin : g_stage
            logic           w_vin;
            logic           w_rdy_next;
            logic [RMW-1:0] w_rem_in  [NUM_LANES];
            logic [R-1:0]   w_root_in [NUM_LANES];
            logic [NW-1:0]  w_rest_in [NUM_LANES];
            logic [RMW-1:0] w_remw    [NUM_LANES];
            logic [RMW-1:0] w_trial   [NUM_LANES];
            logic           w_ge      [NUM_LANES];

            if (s == 0) begin : g_first
                assign w_vin = i_valid;
                always_comb begin
                    for (int l = 0; l < NUM_LANES; l++) begin
                        w_rem_in[l]  = '0;
                        w_root_in[l] = '0;
                        w_rest_in[l] = i_sum[l];
                    end
                end
            end else begin : g_next
                assign w_vin = r_v[s-1];
                always_comb begin
                    for (int l = 0; l < NUM_LANES; l++) begin
                        w_rem_in[l]  = r_rem[s-1][l];
                        w_root_in[l] = r_root[s-1][l];
                        w_rest_in[l] = r_rest[s-1][l];
                    end
                end
            end

            if (s == R - 1) begin : g_last
                assign w_rdy_next = i_ready;
            end else begin : g_mid
                assign w_rdy_next = w_rdy[s+1];
            end

            assign w_rdy[s] = !r_v[s] || w_rdy_next;

            always_comb begin
                for (int l = 0; l < NUM_LANES; l++) begin
                    w_remw[l]  = {w_rem_in[l][RMW-3:0], w_rest_in[l][NW-1 -: 2]};
                    w_trial[l] = RMW'({w_root_in[l], 2'b01});
                    w_ge[l]    = (w_remw[l] >= w_trial[l]);
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (w_rdy[s]) begin
                    r_v[s] <= w_vin;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[s]) begin
                    for (int l = 0; l < NUM_LANES; l++) begin
                        r_rem[s][l]  <= w_ge[l] ? (w_remw[l] - w_trial[l]) : w_remw[l];
                        r_root[s][l] <= {w_root_in[l][R-2:0], w_ge[l]};
                        r_rest[s][l] <= {w_rest_in[l][NW-3:0], 2'b00};
                    end
                end
            end
        end
    endgenerate

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[R-1];
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            o_root[l] = r_root[R-1][l];
        end
    end

`ifndef SYNTHESIS
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[R-1] |-> (r_rem[R-1][0] <= RMW'({r_root[R-1][0], 1'b0}))
                  && (r_rem[R-1][1] <= RMW'({r_root[R-1][1], 1'b0}))
                  && (r_rem[R-1][2] <= RMW'({r_root[R-1][2], 1'b0})))
        else $error("square root remainder exceeds twice the root");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[R-1] && !i_ready) |=> r_v[R-1] && $stable(r_root[R-1][0])
                                  && $stable(r_root[R-1][2]))
        else $error("stalled root changed");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v[0])
        else $error("accepted item lost at first root stage");
`endif
endmodule

/* rtl/tcisd_combine.sv */
// Back stages: radius offsets, union and island selection, sign and saturation.
// Depends on tcisd_pkg.
module tcisd_combine import tcisd_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [COORD_WIDTH:0]      i_root [NUM_LANES],
    input  t_cfg                      i_cfg,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [FIELD_W-1:0] o_dist
);
    localparam int W = COORD_WIDTH;
    localparam logic signed [DIST_W-1:0] LIM_HI = DIST_W'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [DIST_W-1:0] LIM_LO = -LIM_HI - DIST_W'(1);

    logic [2:0]               r_v;
    logic [2:0]               w_rdy;
    logic signed [DIST_W-1:0] w_root [NUM_LANES];
    logic signed [DIST_W-1:0] w_rad  [NUM_LANES];
    logic signed [DIST_W-1:0] r_da;
    logic signed [DIST_W-1:0] r_db;
    logic signed [DIST_W-1:0] r_dc;
    logic signed [DIST_W-1:0] n_d;
    logic signed [DIST_W-1:0] r_d;
    logic signed [DIST_W-1:0] n_sat;
    logic signed [FIELD_W-1:0] r_out;

    assign w_rdy[2] = !r_v[2] || i_ready;
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_v[2];
    assign o_dist   = r_out;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_root[l] = $signed(DIST_W'(i_root[l]));
            w_rad[l]  = $signed(DIST_W'(i_cfg.radius[l]));
        end
    end

    always_comb begin
        n_d = (r_da < r_db) ? r_da : r_db;
        if (n_d < 0 && r_dc > n_d) begin
            n_d = r_dc;
        end
        if (i_cfg.invert) begin
            n_d = -n_d;
        end
    end

    always_comb begin
        if (r_d > LIM_HI) begin
            n_sat = LIM_HI;
        end else if (r_d < LIM_LO) begin
            n_sat = LIM_LO;
        end else begin
            n_sat = r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_da <= w_root[0] - w_rad[0];
            r_db <= w_root[1] - w_rad[1];
            r_dc <= w_rad[2] - w_root[2];
        end
        if (w_rdy[1]) begin
            r_d <= n_d;
        end
        if (w_rdy[2]) begin
            r_out <= FIELD_W'(n_sat);
        end
    end
endmodule

/* rtl/twin_circle_island_signed_distance.sv */
// Top level of the twin circle island signed distance block: configuration registers
// and the three pipeline sections. Depends on tcisd_pkg, the interfaces and all modules.
//
// The block takes one point per cycle unless back-pressure from the output holds it,
// and returns its signed distance after three front stages for differences, squares
// and sums, one stage per root bit in the square root pipeline, and three back
// stages. The square root pipeline is the deepest of the three sections. Every
// stage holds its item under back-pressure and empty stages fill while the output
// waits. Configuration writes are always accepted and belong in idle periods.
module twin_circle_island_signed_distance import tcisd_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcisd_point_if.sink  i_point,
    tcisd_dist_if.source o_dist,
    tcisd_cfg_if.sink    i_cfg
);
    localparam int W = COORD_WIDTH;

    t_cfg              r_cfg;
    logic              w_f_valid;
    logic              w_f_ready;
    logic [2*W+1:0]    w_sum [NUM_LANES];
    logic              w_s_valid;
    logic              w_s_ready;
    logic [W:0]        w_root [NUM_LANES];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_CENTER_A: r_cfg.center[0] <= i_cfg.data;
                REG_RADIUS_A: r_cfg.radius[0] <= i_cfg.data[RADIUS_W-1:0];
                REG_CENTER_B: r_cfg.center[1] <= i_cfg.data;
                REG_RADIUS_B: r_cfg.radius[1] <= i_cfg.data[RADIUS_W-1:0];
                REG_CENTER_C: r_cfg.center[2] <= i_cfg.data;
                REG_RADIUS_C: r_cfg.radius[2] <= i_cfg.data[RADIUS_W-1:0];
                REG_INVERT:   r_cfg.invert    <= i_cfg.data[0];
                default:      r_cfg           <= r_cfg;
            endcase
        end
    end

    tcisd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_point.valid),
        .o_ready (i_point.ready),
        .i_px    (i_point.point_x),
        .i_py    (i_point.point_y),
        .i_cfg   (r_cfg),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_sum   (w_sum)
    );

    tcisd_sqrt #(.COORD_WIDTH(COORD_WIDTH)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_sum   (w_sum),
        .o_valid (w_s_valid),
        .i_ready (w_s_ready),
        .o_root  (w_root)
    );

    tcisd_combine #(.COORD_WIDTH(COORD_WIDTH)) u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s_valid),
        .o_ready (w_s_ready),
        .i_root  (w_root),
        .i_cfg   (r_cfg),
        .o_valid (o_dist.valid),
        .i_ready (o_dist.ready),
        .o_dist  (o_dist.signed_distance)
    );
endmodule
